>>> rtl/mbrtu_pkg.sv
// Shared constants, types and helpers for the Modbus RTU master core.
package mbrtu_pkg;

	localparam int FRAME_BYTES_DEF = 128;
	localparam int MAX_REGS_DEF = 61;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_END = 2'd2;

	localparam logic [1:0] KIND_REQ = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_CRC = 2'd2;
	localparam logic [1:0] ST_EXC = 2'd3;

	localparam logic [7:0] FC_READ = 8'h03;
	localparam logic [7:0] FC_WRITE = 8'h06;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [2:0] REG_SLAVE = 3'd0;
	localparam logic [2:0] REG_FUNC = 3'd1;
	localparam logic [2:0] REG_ADDR = 3'd2;
	localparam logic [2:0] REG_COUNT = 3'd3;
	localparam logic [2:0] REG_VALUE = 3'd4;

	// Queue entry between front and back: which job to run.
	typedef struct packed {
		logic [1:0] op;   // OP_START or OP_END
		logic [1:0] st;   // frame status for OP_END
		logic [5:0] cnt;  // registers to emit after status
	} job_t;

	typedef struct packed {
		logic [7:0] slave;
		logic func;
		logic [15:0] addr;
		logic [5:0] count;
		logic [15:0] value;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] request_byte(input cfg_t cfg, input logic [2:0] i);
		logic [15:0] arg;
		logic [7:0] r;
		arg = cfg.func ? cfg.value : {10'd0, cfg.count};
		case (i)
			3'd0: r = cfg.slave;
			3'd1: r = cfg.func ? FC_WRITE : FC_READ;
			3'd2: r = cfg.addr[15:8];
			3'd3: r = cfg.addr[7:0];
			3'd4: r = arg[15:8];
			default: r = arg[7:0];
		endcase
		return r;
	endfunction

endpackage

>>> rtl/mbrtu_ram.sv
// Generic single-port-write, registered-read RAM.
module mbrtu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 61
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/mbrtu_front.sv
// Front end: takes requests, tracks the receive frame, classifies frame end.
module mbrtu_front #(
	parameter int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES_DEF,
	parameter int MAX_REGS = mbrtu_pkg::MAX_REGS_DEF,
	localparam int AW = $clog2(MAX_REGS),
	localparam int CW = $clog2(FRAME_BYTES + 1)
) (
	input logic clk,
	input logic arst_n,
	input mbrtu_pkg::cfg_t cfg,
	input logic in_valid,
	input logic [1:0] opcode,
	input logic [7:0] rx_byte,
	output logic in_stall,
	output logic job_valid,
	output mbrtu_pkg::job_t job,
	input logic job_full,
	input logic back_busy,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [15:0] wr_data
);
	logic [CW-1:0] byte_count_q;
	logic [15:0] crc_q, lag_q;
	logic [23:0] hdr_q;
	logic echo_bad_q;
	logic [7:0] high_q;

	logic take, is_job;
	logic [CW-1:0] limit;
	logic [CW-1:0] d;
	logic [15:0] rx_crc;
	logic [1:0] st;
	logic [7:0] h0, h1, h2;
	logic [7:0] cnt2;

	// the queue only gets start and frame end; bytes go straight through
	assign is_job = (opcode == mbrtu_pkg::OP_START) || (opcode == mbrtu_pkg::OP_END);
	// hold response bytes while the back end may still read the value RAM
	assign in_stall = (is_job && job_full) || (opcode == mbrtu_pkg::OP_BYTE && back_busy);
	assign take = in_valid && !in_stall;
	assign limit = cfg.func ? CW'(8) : CW'(FRAME_BYTES);
	assign d = byte_count_q - CW'(3);

	assign rx_crc = {lag_q[7:0], lag_q[15:8]};
	assign h0 = hdr_q[23:16];
	assign h1 = hdr_q[15:8];
	assign h2 = hdr_q[7:0];
	assign cnt2 = {1'b0, cfg.count, 1'b0};

	always_comb begin
		if (cfg.func) begin
			if (byte_count_q < CW'(8)) st = mbrtu_pkg::ST_BAD;
			else if (crc_q != rx_crc) st = mbrtu_pkg::ST_CRC;
			else if (h1[7]) st = mbrtu_pkg::ST_EXC;
			else if (h0 != cfg.slave || h1 != mbrtu_pkg::FC_WRITE || echo_bad_q)
				st = mbrtu_pkg::ST_BAD;
			else st = mbrtu_pkg::ST_OK;
		end else begin
			if (byte_count_q < CW'(5)) st = mbrtu_pkg::ST_BAD;
			else if (crc_q != rx_crc) st = mbrtu_pkg::ST_CRC;
			else if (h1[7]) st = mbrtu_pkg::ST_EXC;
			else if (h0 != cfg.slave || h1 != mbrtu_pkg::FC_READ || h2 != cnt2
				|| 9'(byte_count_q) != 9'd5 + 9'(cnt2)
				|| 7'(cfg.count) > 7'(MAX_REGS))
				st = mbrtu_pkg::ST_BAD;
			else st = mbrtu_pkg::ST_OK;
		end
	end

	assign job_valid = take && is_job;
	assign job.op = opcode;
	assign job.st = st;
	assign job.cnt = (st == mbrtu_pkg::ST_OK && !cfg.func) ? cfg.count : 6'd0;

	assign wr_en = take && opcode == mbrtu_pkg::OP_BYTE && byte_count_q < limit
		&& !cfg.func && byte_count_q >= CW'(3) && d[0]
		&& 32'(d[CW-1:1]) < MAX_REGS;
	assign wr_addr = AW'(d[CW-1:1]);
	assign wr_data = {high_q, rx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q <= mbrtu_pkg::CRC_INIT;
			lag_q <= '0;
			hdr_q <= '0;
			echo_bad_q <= 1'b0;
			high_q <= '0;
		end else if (take) begin
			if (is_job) begin
				byte_count_q <= '0;
				crc_q <= mbrtu_pkg::CRC_INIT;
				lag_q <= '0;
				hdr_q <= '0;
				echo_bad_q <= 1'b0;
				high_q <= '0;
			end else if (opcode == mbrtu_pkg::OP_BYTE && byte_count_q < limit) begin
				if (byte_count_q >= CW'(2)) crc_q <= mbrtu_pkg::crc_byte(crc_q, lag_q[15:8]);
				lag_q <= {lag_q[7:0], rx_byte};
				if (byte_count_q == CW'(0)) hdr_q[23:16] <= rx_byte;
				if (byte_count_q == CW'(1)) hdr_q[15:8] <= rx_byte;
				if (byte_count_q == CW'(2)) hdr_q[7:0] <= rx_byte;
				if (cfg.func) begin
					if (byte_count_q < CW'(6)
						&& rx_byte != mbrtu_pkg::request_byte(cfg, byte_count_q[2:0]))
						echo_bad_q <= 1'b1;
				end else if (byte_count_q >= CW'(3) && !d[0]) begin
					high_q <= rx_byte;
				end
				byte_count_q <= byte_count_q + CW'(1);
			end
		end
	end
endmodule

>>> rtl/mbrtu_queue.sv
// Two-entry job queue between front and back.
module mbrtu_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mbrtu_pkg::job_t push_job,
	output logic full,
	output logic pop_valid,
	output mbrtu_pkg::job_t pop_job,
	input logic pop
);
	mbrtu_pkg::job_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] fill_q;

	assign full = fill_q == 2'd2;
	assign pop_valid = fill_q != 2'd0;
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> rtl/mbrtu_back.sv
// Back end: emits request bytes, status and stored register values.
module mbrtu_back #(
	parameter int MAX_REGS = mbrtu_pkg::MAX_REGS_DEF,
	localparam int AW = $clog2(MAX_REGS)
) (
	input logic clk,
	input logic arst_n,
	input mbrtu_pkg::cfg_t cfg,
	input logic job_valid,
	input mbrtu_pkg::job_t job,
	output logic job_pop,
	output logic busy,
	output logic [AW-1:0] rd_addr,
	input logic [15:0] rd_data,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [15:0] data,
	output logic [5:0] reg_index,
	output logic [1:0] status,
	output logic last
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_REQ = 2'd1;
	localparam logic [1:0] S_VAL = 2'd2;

	logic [1:0] state_q;
	logic [5:0] idx_q, cnt_q;
	logic [15:0] crc_q;
	logic rd_ok_q;       // rd_data holds entry idx_q
	logic slot_free, fire;
	logic [7:0] rb;

	assign slot_free = !out_valid || !out_stall;
	assign rb = mbrtu_pkg::request_byte(cfg, idx_q[2:0]);
	assign job_pop = state_q == S_IDLE && job_valid && slot_free;
	assign busy = state_q != S_IDLE;
	assign rd_addr = AW'(idx_q);
	assign fire = slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			crc_q <= mbrtu_pkg::CRC_INIT;
			rd_ok_q <= 1'b0;
			kind <= '0;
			data <= '0;
			reg_index <= '0;
			status <= '0;
			last <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			rd_ok_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_pop) begin
						idx_q <= '0;
						if (job.op == mbrtu_pkg::OP_START) begin
							crc_q <= mbrtu_pkg::CRC_INIT;
							state_q <= S_REQ;
						end else begin
							out_valid <= 1'b1;
							kind <= mbrtu_pkg::KIND_STATUS;
							data <= '0;
							reg_index <= '0;
							status <= job.st;
							last <= job.cnt == 6'd0;
							cnt_q <= job.cnt;
							if (job.cnt != 6'd0) state_q <= S_VAL;
						end
					end
				end
				S_REQ: begin
					if (fire) begin
						out_valid <= 1'b1;
						kind <= mbrtu_pkg::KIND_REQ;
						reg_index <= '0;
						status <= '0;
						idx_q <= idx_q + 6'd1;
						if (idx_q < 6'd6) begin
							data <= {8'h00, rb};
							crc_q <= mbrtu_pkg::crc_byte(crc_q, rb);
							last <= 1'b0;
						end else if (idx_q == 6'd6) begin
							data <= {8'h00, crc_q[7:0]};
							last <= 1'b0;
						end else begin
							data <= {8'h00, crc_q[15:8]};
							last <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_VAL: begin
					// wait for the registered read of entry idx_q
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (fire) begin
						out_valid <= 1'b1;
						kind <= mbrtu_pkg::KIND_VALUE;
						data <= rd_data;
						reg_index <= idx_q;
						status <= '0;
						last <= idx_q + 6'd1 == cnt_q;
						idx_q <= idx_q + 6'd1;
						if (idx_q + 6'd1 == cnt_q) state_q <= S_IDLE;
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/modbus_rtu_master_transaction_core.sv
// Top level of the Modbus RTU master transaction core.
// Usage: program slave_address, function_select, register_address,
// register_count and write_value over the APB port (byte addresses 0,4,..,16)
// while idle. Input channel (in_valid/in_stall, opcode, rx_byte): opcode 0
// starts a transaction, 1 delivers one response byte, 2 marks frame end.
// Output channel (out_valid/out_stall): a start yields 8 request bytes (kind 0),
// CRC low byte first; a frame end yields one status (kind 1), then after a
// good read register_count values (kind 2) in order; last marks the final one.
// Response bytes are absorbed at one per cycle while in_stall is low, with no
// output. The back-end sequencer reads the value RAM (registered read) once
// per value and waits for each read before it sends the value. Start and
// frame-end requests pass through a two-entry job queue; response bytes
// stall while a job is queued or the back end is busy, so a new frame never
// overwrites values still being sent.
// Reset clears all control state and the registers; the value RAM is not
// cleared. When the receiver stalls, the output holds, the back end waits,
// and once the queue fills the input stalls on start and frame-end requests.
module modbus_rtu_master_transaction_core #(
	parameter int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES_DEF,
	parameter int MAX_REGS = mbrtu_pkg::MAX_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] opcode,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [15:0] data,
	output logic [5:0] reg_index,
	output logic [1:0] status,
	output logic last
);
	localparam int AW = $clog2(MAX_REGS);

	mbrtu_pkg::cfg_t cfg_q;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				mbrtu_pkg::REG_SLAVE: cfg_q.slave <= pwdata[7:0];
				mbrtu_pkg::REG_FUNC: cfg_q.func <= pwdata[0];
				mbrtu_pkg::REG_ADDR: cfg_q.addr <= pwdata[15:0];
				mbrtu_pkg::REG_COUNT: cfg_q.count <= pwdata[5:0];
				mbrtu_pkg::REG_VALUE: cfg_q.value <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			mbrtu_pkg::REG_SLAVE: prdata = {24'd0, cfg_q.slave};
			mbrtu_pkg::REG_FUNC: prdata = {31'd0, cfg_q.func};
			mbrtu_pkg::REG_ADDR: prdata = {16'd0, cfg_q.addr};
			mbrtu_pkg::REG_COUNT: prdata = {26'd0, cfg_q.count};
			mbrtu_pkg::REG_VALUE: prdata = {16'd0, cfg_q.value};
			default: prdata = '0;
		endcase
	end

	logic push, full, pop_valid, pop;
	logic back_busy;
	mbrtu_pkg::job_t push_job, pop_job;
	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [15:0] wr_data, rd_data;

	mbrtu_front #(.FRAME_BYTES(FRAME_BYTES), .MAX_REGS(MAX_REGS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .opcode(opcode), .rx_byte(rx_byte), .in_stall(in_stall),
		.job_valid(push), .job(push_job), .job_full(full),
		.back_busy(pop_valid || back_busy),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	mbrtu_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop_valid(pop_valid), .pop_job(pop_job), .pop(pop)
	);

	mbrtu_ram #(.WIDTH(16), .DEPTH(MAX_REGS)) u_ram (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd_data)
	);

	mbrtu_back #(.MAX_REGS(MAX_REGS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.job_valid(pop_valid), .job(pop_job), .job_pop(pop), .busy(back_busy),
		.rd_addr(rd_addr), .rd_data(rd_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data(data), .reg_index(reg_index), .status(status), .last(last)
	);
endmodule
